// File: design/spq_pkg.sv
// Shared types and codes for the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  // One stored entry: identifier, burst time and priority.
  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [15:0] proc_id;
  } entry_t;

  // Command codes carried on the input tuser.
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_POP    = 1'b1
  } cmd_t;

  // Result status codes carried on the output tuser.
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_POPPED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Control broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

// File: design/spq_cell.sv
// One cell of the sorted chain: holds a single entry and shifts with its neighbours.
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic               occupied,
  input  logic               at_end,
  input  spq_pkg::entry_t    prev_entry,
  input  logic               prev_take,
  input  spq_pkg::entry_t    next_entry,
  output spq_pkg::entry_t    entry,
  output logic               take
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // A held entry with a strictly larger priority gives way to the new one,
  // which keeps equal priorities in arrival order. The first free cell takes
  // the new entry when no held entry gives way.
  assign take  = occupied ? (entry_r.prio > ctrl.new_entry.prio) : at_end;
  assign entry = entry_r;

  // Insert shifts the tail one place back; pop shifts everything forward.
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins && take) begin
      entry_nxt = prev_take ? prev_entry : ctrl.new_entry;
    end else if (ctrl.pop) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// File: design/stable_priority_queue.sv
// Top level of the stable priority queue built as a chain of sorted cells.
//
// Usage: each input beat carries one command. in_tuser selects insert or pop,
// in_tdata carries the entry to insert (identifier, burst time, priority).
// Every command produces exactly one output beat: out_tuser gives the status
// (inserted, popped, pop on empty, insert dropped because full) and
// out_tdata the popped entry, or zeros when nothing was popped.
// Smaller priority values leave first; equal priorities leave in arrival order.
// An accepted input beat has its output beat in the next cycle; while the
// receiver takes results a command can be accepted in every cycle: all cells
// compare against the new priority at once and shift in the same clock, so
// the chain of DEPTH cells sets no limit on rate beyond one command per cycle.
// The result sits in an output register; while the receiver stalls, a new
// beat is accepted only in the cycle in which the waiting result is taken.
// Reset empties the queue at once (occupancy count cleared); stored entries
// are not cleared and are never read before being written.
`timescale 1ns / 1ps

module stable_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // proc_id[15:0], burst[31:16], prio[39:32]
  input  logic        in_tuser,   // command[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_id[15:0], out_burst[31:16], out_prio[39:32]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import spq_pkg::*;

  localparam int OCC_W = $clog2(DEPTH + 1);

  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;
  logic             out_valid_r;
  logic [39:0]      out_data_r;
  logic [1:0]       out_user_r;
  logic [39:0]      out_data_nxt;
  status_t          status_nxt;

  logic       in_fire;
  logic       is_pop;
  logic       full;
  logic       empty;
  cell_ctrl_t ctrl;

  entry_t cell_entry [DEPTH];
  logic   cell_take  [DEPTH];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign is_pop    = (in_tuser == CMD_POP);
  assign full      = (occ_r == OCC_W'(DEPTH));
  assign empty     = (occ_r == '0);

  // Broadcast control to the chain; only legal operations move the cells.
  always_comb begin
    ctrl.new_entry.proc_id = in_tdata[15:0];
    ctrl.new_entry.burst   = in_tdata[31:16];
    ctrl.new_entry.prio    = in_tdata[39:32];
    ctrl.ins               = in_fire && !is_pop && !full;
    ctrl.pop               = in_fire && is_pop && !empty;
  end

  // The chain of cells, cell zero at the head.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prev_e;
    logic   prev_t;
    entry_t next_e;

    if (i == 0) begin : g_head
      assign prev_e = ctrl.new_entry;
      assign prev_t = 1'b0;
    end else begin : g_mid
      assign prev_e = cell_entry[i-1];
      assign prev_t = cell_take[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_e = cell_entry[i];
    end else begin : g_body
      assign next_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (OCC_W'(i) < occ_r),
      .at_end     (occ_r == OCC_W'(i)),
      .prev_entry (prev_e),
      .prev_take  (prev_t),
      .next_entry (next_e),
      .entry      (cell_entry[i]),
      .take       (cell_take[i])
    );
  end

  // Result and occupancy for the accepted command.
  always_comb begin
    occ_nxt      = occ_r;
    out_data_nxt = '0;
    if (is_pop) begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        status_nxt   = ST_POPPED;
        out_data_nxt = {cell_entry[0].prio, cell_entry[0].burst, cell_entry[0].proc_id};
        occ_nxt      = occ_r - 1'b1;
      end
    end else begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt = ST_INSERTED;
        occ_nxt    = occ_r + 1'b1;
      end
    end
  end

  // Control state: occupancy count and output beat valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        occ_r <= occ_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
      out_user_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Occupancy never passes the number of cells.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("occupancy beyond depth");

  // An insert into a full queue is reported as dropped and leaves the count.
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !is_pop && full) |=>
      (out_tvalid && out_tuser == ST_FULL && occ_r == $past(occ_r)))
    else $error("full insert not dropped");

  // A pop on an empty queue is reported as such with zero payload.
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_pop && empty) |=>
      (out_tvalid && out_tuser == ST_EMPTY && out_tdata == '0 && occ_r == '0))
    else $error("empty pop misreported");

  // A successful insert grows the count by one.
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !is_pop && !full) |=> (occ_r == $past(occ_r) + 1'b1))
    else $error("insert did not grow occupancy");

endmodule
